// ===== sv/aled_pkg.sv =====
// ----------------------------------------------------------------------------
// aled_pkg
// Shared codes, widths and helpers for the addressable LED frame driver.
// ----------------------------------------------------------------------------
package aled_pkg;

	localparam int COLOR_W = 24;
	localparam int TICK_W  = 8;
	localparam int BIT_W   = 5;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int LED_CNT_W  = 9;

	localparam logic [BIT_W-1:0] BITS_PER_LED = 5'd24;
	localparam logic [BIT_W-1:0] TOP_BIT      = 5'd23;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_ALL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd4;

	typedef logic [TICK_W-1:0] ticks_t;

	// a zero duration counts as one tick
	function automatic ticks_t at_least_one(input ticks_t v);
		return (v == '0) ? ticks_t'(1) : v;
	endfunction

endpackage

// ===== sv/addressable_led_frame_driver_unit.sv =====
// ----------------------------------------------------------------------------
// addressable_led_frame_driver_unit
// Colour store plus serial waveform generator for a chain of addressable LEDs.
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------
// item     | item_valid / item_stall    | cmd, pixel_index, red, green, blue
// result   | result_valid / result_stall| status, line_level, sending,
//          |                            | frame_done
// config   | cfg_wen                    | cfg_index, cfg_data
//
// A tick that ends an LED other than the last, and a start-frame command, are
// followed by a load step that takes the next colour, read from the store, and
// starts its first high phase while item_stall is held high.
// Set-pixel makes one store write, set-all one store write per LED.
// After reset a clearing pass writes zero to all MAX_LEDS entries, one per
// cycle, while item_stall is held high.
// A held result_stall holds the result and, through item_stall, the input.
// ----------------------------------------------------------------------------
module addressable_led_frame_driver_unit
	import aled_pkg::*;
#(
	parameter int MAX_LEDS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [7:0]            pixel_index,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [STAT_W-1:0]     status,
	output logic                  line_level,
	output logic                  sending,
	output logic                  frame_done
);

	localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CW0 = $clog2(MAX_LEDS + 1);
	localparam int CW  = (CW0 > LED_CNT_W) ? CW0 : LED_CNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEDS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

	// configuration
	logic [LED_CNT_W-1:0] led_count_q;
	ticks_t zero_high_q, zero_low_q, one_high_q, one_low_q;

	// colour store
	logic [COLOR_W-1:0] mem [MAX_LEDS];
	logic [COLOR_W-1:0] rd_data_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;

	// fill sweep (reset clear and set-all)
	logic               sweep_q;
	logic [AW-1:0]      sweep_addr_q;
	logic [AW-1:0]      sweep_end_q;
	logic [COLOR_W-1:0] sweep_data_q;

	// frame state
	logic               busy_q;
	logic               load_q;
	logic [AW-1:0]      pos_q;
	logic [BIT_W-1:0]   bit_q;
	logic               low_q;
	ticks_t             ticks_q;

	logic [CW-1:0]      cnt_ext;
	logic [CW-1:0]      n_eff;
	logic               accept;
	logic               out_take;
	logic [COLOR_W-1:0] colour;
	logic               in_range;
	logic               cur_bit;
	logic [BIT_W-1:0]   bit_nx;
	logic               nx_bit;
	logic               last_led;
	logic               tick_end;

	assign cnt_ext = CW'(led_count_q);
	always_comb begin
		if (cnt_ext == '0) begin
			n_eff = CW'(1);
		end else if (cnt_ext > MAX_CNT) begin
			n_eff = MAX_CNT;
		end else begin
			n_eff = cnt_ext;
		end
	end

	assign out_take   = result_valid & ~result_stall;
	assign item_stall = sweep_q | load_q | (result_valid & result_stall);
	assign accept     = item_valid & ~item_stall;
	assign colour     = {green, red, blue};
	assign in_range   = CW'(pixel_index) < n_eff;

	assign cur_bit  = rd_data_q[TOP_BIT - bit_q];
	assign bit_nx   = bit_q + 5'd1;
	assign nx_bit   = rd_data_q[TOP_BIT - bit_nx];
	assign last_led = (CW'(pos_q) + CW'(1)) >= n_eff;
	assign tick_end = (ticks_q <= ticks_t'(1));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_CNT_W'(1);
			zero_high_q <= ticks_t'(4);
			zero_low_q  <= ticks_t'(8);
			one_high_q  <= ticks_t'(8);
			one_low_q   <= ticks_t'(4);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LED_COUNT: led_count_q <= cfg_data;
				REG_ZERO_HIGH: zero_high_q <= cfg_data[TICK_W-1:0];
				REG_ZERO_LOW:  zero_low_q  <= cfg_data[TICK_W-1:0];
				REG_ONE_HIGH:  one_high_q  <= cfg_data[TICK_W-1:0];
				REG_ONE_LOW:   one_low_q   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_addr_q;
		mem_wdata = sweep_data_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		if (sweep_q) begin
			mem_we = 1'b1;
		end else if (accept && !busy_q && cmd == CMD_SET_PIXEL && in_range) begin
			mem_we    = 1'b1;
			mem_waddr = CW'(pixel_index) < MAX_CNT ? AW'(pixel_index) : '0;
			mem_wdata = colour;
		end
		if (accept && !busy_q && cmd == CMD_START) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if (accept && busy_q && cmd == CMD_TICK && tick_end && low_q
			&& bit_nx == BITS_PER_LED && !last_led) begin
			rd_en   = 1'b1;
			rd_addr = pos_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// fill sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			sweep_end_q  <= LAST_ADDR;
			sweep_data_q <= '0;
		end else if (sweep_q) begin
			if (sweep_addr_q == sweep_end_q) begin
				sweep_q <= 1'b0;
			end else begin
				sweep_addr_q <= sweep_addr_q + AW'(1);
			end
		end else if (accept && !busy_q && cmd == CMD_SET_ALL) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			sweep_end_q  <= AW'(n_eff - CW'(1));
			sweep_data_q <= colour;
		end
	end

	// waveform sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			load_q  <= 1'b0;
			pos_q   <= '0;
			bit_q   <= '0;
			low_q   <= 1'b0;
			ticks_q <= '0;
		end else if (load_q) begin
			// colour of the new led has arrived, start its first high phase
			load_q  <= 1'b0;
			ticks_q <= at_least_one(rd_data_q[TOP_BIT] ? one_high_q : zero_high_q);
		end else if (accept) begin
			if (!busy_q && cmd == CMD_START) begin
				busy_q <= 1'b1;
				load_q <= 1'b1;
				pos_q  <= '0;
				bit_q  <= '0;
				low_q  <= 1'b0;
			end else if (busy_q && cmd == CMD_TICK) begin
				if (tick_end) begin
					if (!low_q) begin
						low_q   <= 1'b1;
						ticks_q <= at_least_one(cur_bit ? one_low_q : zero_low_q);
					end else begin
						low_q <= 1'b0;
						if (bit_nx == BITS_PER_LED) begin
							bit_q   <= '0;
							ticks_q <= '0;
							if (last_led) begin
								busy_q <= 1'b0;
								pos_q  <= '0;
							end else begin
								pos_q  <= pos_q + AW'(1);
								load_q <= 1'b1;
							end
						end else begin
							bit_q   <= bit_nx;
							ticks_q <= at_least_one(nx_bit ? one_high_q : zero_high_q);
						end
					end
				end else begin
					ticks_q <= ticks_q - ticks_t'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			status       <= STAT_OK;
			line_level   <= 1'b0;
			sending      <= 1'b0;
			frame_done   <= 1'b0;
		end else if (accept) begin
			result_valid <= 1'b1;
			if (cmd == CMD_TICK) begin
				status     <= STAT_OK;
				line_level <= busy_q & ~low_q;
				sending    <= busy_q;
				frame_done <= busy_q & tick_end & low_q & (bit_nx == BITS_PER_LED)
					& last_led;
			end else begin
				line_level <= 1'b0;
				frame_done <= 1'b0;
				sending    <= busy_q | (cmd == CMD_START);
				if (busy_q) begin
					status <= STAT_BUSY;
				end else if (cmd == CMD_SET_PIXEL && !in_range) begin
					status <= STAT_RANGE;
				end else begin
					status <= STAT_OK;
				end
			end
		end else if (out_take) begin
			result_valid <= 1'b0;
		end
	end

	// a frame and a fill sweep never run together
	assert property (@(posedge clk) disable iff (!arst_n) !(busy_q && sweep_q))
		else $error("fill sweep overlaps a frame");

	// a pending colour load only happens inside a frame
	assert property (@(posedge clk) disable iff (!arst_n) load_q |-> busy_q)
		else $error("colour load outside a frame");

	// the last tick of a frame ends the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && busy_q && cmd == CMD_TICK && tick_end && low_q
			&& bit_nx == BITS_PER_LED && last_led) |=> (!busy_q && frame_done))
		else $error("frame did not close on its final tick");

	// every accepted transaction leaves a result behind
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> result_valid)
		else $error("accepted transaction produced no result");

endmodule
